[hdl/bdq_pkg.sv]
// Shared types and constants for the bounded deque with search.
`default_nettype none

package bdq_pkg;

  // Word width of one stored entry.
  localparam int unsigned WORD_W = 32;

  // Default number of cells in the chain.
  localparam int unsigned DEPTH_DEF = 16;

  // Capacity register: reset value and width.
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Configuration register index, decoded from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  // Opcodes.
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     found;
    logic [4:0]               item_count;
    logic                     is_empty;
    logic                     is_full;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
  } out_word_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic take_prev;   // shift toward the rear (push front)
    logic take_next;   // shift toward the front (pop front)
    logic write_tail;  // cell at the fill count takes the word (push rear)
    logic compare;     // latch the match bit against the word
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/bounded_deque_with_search_core.sv]
// Top level of the bounded deque with search: control, chain of cells and register port.
`default_nettype none

// Usage
// The input channel (in_valid, in_stall, in_data) carries one operation word: an
// opcode (push front, push rear, pop front, pop rear, search, status) and a value.
// Each accepted word yields exactly one result word on the output channel
// (out_valid, out_stall, out_data): status, search hit, count, empty and full
// flags, and the front and rear entries after the operation.
// The accepting edge moves the chain of cells and latches per-cell match bits;
// in the execute state the match bits are reduced and the rear entry is
// picked into the output register once that register is free. The block takes
// no new word until then.
// If the receiver stalls, the result waits in the output register and the block
// still takes the next word; that word then holds in the execute state until
// the output register frees up.
// Reset empties the deque and sets capacity to its reset value; cell contents
// are not cleared since only occupied cells are ever read.
// The capacity register sits at byte address 0 of the APB-style port and may be
// written only while no operation is in flight.

module bounded_deque_with_search_core #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  // Input channel
  input  wire                       in_valid,
  output logic                      in_stall,
  input  bdq_pkg::in_word_t         in_data,
  // Result channel
  output logic                      out_valid,
  input  wire                       out_stall,
  output bdq_pkg::out_word_t        out_data,
  // Configuration port
  input  wire                       cfg_psel,
  input  wire                       cfg_penable,
  input  wire                       cfg_pwrite,
  input  wire [2:0]                 cfg_paddr,
  input  wire [31:0]                cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import bdq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Width wide enough to compare the count with the 5-bit capacity.
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [1:0]       status_r;
  logic [1:0]       status_nxt;
  logic             is_search_r;
  logic             out_valid_r;
  out_word_t        out_data_r;

  logic             in_acc;
  logic             out_free;
  cell_ctrl_t       ctrl;

  logic [WORD_W-1:0] cell_data  [DEPTH];
  logic [DEPTH-1:0]  cell_match;

  // ------------------------------------------------------------------
  // Configuration port. Only paddr[2] selects the register; one register.
  // ------------------------------------------------------------------
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_CAPACITY)) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_CAPACITY) begin
      cfg_prdata = 32'(cap_r);
    end
  end

  // Effective capacity: zero acts as one, anything above DEPTH acts as DEPTH.
  logic [CMP_W-1:0] cap_eff;
  logic [CMP_W-1:0] count_ext;

  always_comb begin
    cap_eff = CMP_W'(cap_r);
    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end
  end

  assign count_ext = CMP_W'(count_r);

  // ------------------------------------------------------------------
  // Operation decode, done in the cycle the word is accepted.
  // ------------------------------------------------------------------
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    ctrl       = '0;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    if (in_acc) begin
      unique case (in_data.opcode)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (count_ext >= cap_eff) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            count_nxt = count_r + CNT_W'(1);
            if (in_data.opcode == OP_PUSH_FRONT) begin
              ctrl.take_prev = 1'b1;
            end else begin
              ctrl.write_tail = 1'b1;
            end
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (count_r == '0) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            if (in_data.opcode == OP_POP_FRONT) begin
              ctrl.take_next = 1'b1;
            end
          end
        end
        OP_SEARCH: begin
          ctrl.compare = 1'b1;
        end
        default: begin
          // Status and unused opcodes change nothing.
        end
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Chain of cells. Cell 0 is the front; a front push feeds the new word
  // into cell 0 and every cell takes its predecessor's entry.
  // ------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] prev_d;
    logic [WORD_W-1:0] next_d;

    if (g == 0) begin : g_head
      assign prev_d = in_data.value;
    end else begin : g_body
      assign prev_d = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign next_d = cell_data[g];
    end else begin : g_mid
      assign next_d = cell_data[g+1];
    end

    bdq_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count_r),
      .value     (in_data.value),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[g]),
      .match     (cell_match[g])
    );
  end

  // ------------------------------------------------------------------
  // Result assembly in the execute state.
  // ------------------------------------------------------------------
  logic [CNT_W-1:0] rear_pos;
  logic [IDX_W-1:0] rear_idx;
  out_word_t        result;

  assign rear_pos = count_r - CNT_W'(1);
  assign rear_idx = rear_pos[IDX_W-1:0];

  always_comb begin
    result             = '0;
    result.status      = status_r;
    result.found       = is_search_r && (|cell_match);
    result.item_count  = count_ext[CAP_W-1:0];
    result.is_empty    = (count_r == '0);
    result.is_full     = (count_ext >= cap_eff);
    if (count_r != '0) begin
      result.front_value = cell_data[0];
      result.rear_value  = cell_data[rear_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      // A finished operation loads the output register; otherwise a taken
      // result empties it.
      if (state_r == S_EXEC && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload side of the accept and result stages.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r    <= status_nxt;
      is_search_r <= (in_data.opcode == OP_SEARCH);
    end
    if (state_r == S_EXEC && out_free) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count beyond chain depth");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && out_free) |=> out_valid_r)
    else $error("finished operation did not reach the output register");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (ctrl.take_prev || ctrl.write_tail)) |=>
      (count_r == $past(count_r) + CNT_W'(1)))
    else $error("successful push did not grow the count");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_OVERFLOW) |-> out_data_r.is_full)
    else $error("overflow reported on a deque that is not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_UNDERFLOW) |-> out_data_r.is_empty)
    else $error("underflow reported on a deque that is not empty");

endmodule

`default_nettype wire

[hdl/bdq_cell.sv]
// One cell of the deque chain: holds one entry and its search match bit.
`default_nettype none

module bdq_cell #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX   = 0
) (
  input  wire                                 clk,
  input  bdq_pkg::cell_ctrl_t                 ctrl,
  input  wire [$clog2(DEPTH+1)-1:0]           count,
  input  wire [bdq_pkg::WORD_W-1:0]           value,
  input  wire [bdq_pkg::WORD_W-1:0]           prev_data,
  input  wire [bdq_pkg::WORD_W-1:0]           next_data,
  output logic [bdq_pkg::WORD_W-1:0]          data,
  output logic                                match
);
  import bdq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;
  logic              match_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.take_prev) begin
      data_nxt = prev_data;
    end else if (ctrl.take_next) begin
      data_nxt = next_data;
    end else if (ctrl.write_tail && (count == MY_POS)) begin
      data_nxt = value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctrl.compare) begin
      // Only occupied cells may report a hit.
      match_r <= (data_r == value) && (MY_POS < count);
    end
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the bounded deque with search: stimulus, predictor and checker.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  // Opcodes that the package leaves unnamed. Status only reports the shape of
  // the deque, and the two spare codes must behave exactly like status.
  localparam logic [2:0] OP_STATUS = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int unsigned CELLS = DEPTH_DEF;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  localparam int PHASE_WORDS = 125;
  localparam int N_PHASES = 10;
  localparam int LONG_HOLD_AT = 500;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

  // Capacity of each random phase. Zero and 31 exercise the clamping to one
  // and to the cell count; small values make full and overflow common.
  localparam logic [CAP_W-1:0] CAP_PLAN [N_PHASES] = '{
    5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd2, 5'd16, 5'd4, 5'd15, 5'd31
  };

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  bounded_deque_with_search_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor. It mirrors the deque as a packed array with the front at cell 0
  // and the rear at cell fill-1, plus its own copy of the capacity register.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] shadow_cells [CELLS];
  int unsigned shadow_fill = 0;
  logic [CAP_W-1:0] shadow_cap = CAP_RESET;

  function automatic out_word_t apply_deque_op(in_word_t w);
    out_word_t r;
    int unsigned limit;
    r = '0;
    // A capacity of zero acts as one; anything above the cell count acts as full depth.
    limit = (shadow_cap == 0) ? 1 : ((shadow_cap > CELLS) ? CELLS : shadow_cap);
    r.status = ST_DONE;
    case (w.opcode)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        // The count can exceed the limit after the capacity was lowered.
        if (shadow_fill >= limit) begin
          r.status = ST_OVERFLOW;
        end else begin
          if (w.opcode == OP_PUSH_FRONT) begin
            for (int i = shadow_fill; i > 0; i--) shadow_cells[i] = shadow_cells[i-1];
            shadow_cells[0] = w.value;
          end else begin
            shadow_cells[shadow_fill] = w.value;
          end
          shadow_fill++;
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (shadow_fill == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          if (w.opcode == OP_POP_FRONT) begin
            for (int i = 0; i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i+1];
          end
          shadow_fill--;
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_cells[i] == w.value) r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.item_count = shadow_fill[4:0];
    r.is_empty = (shadow_fill == 0);
    r.is_full = (shadow_fill >= limit);
    r.front_value = (shadow_fill == 0) ? '0 : shadow_cells[0];
    r.rear_value = (shadow_fill == 0) ? '0 : shadow_cells[shadow_fill-1];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Recently pushed values are remembered so that about half
  // of the searches look for a value that was recently pushed.
  // ---------------------------------------------------------------------------
  in_word_t queued_ops [$];
  out_word_t predicted_words [$];
  logic [WORD_W-1:0] recent_pushes [$];
  int failures = 0;
  int results_seen = 0;

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return $urandom_range(0, 1) ? WORD_ONES : '0;
      3, 4: return $urandom_range(0, 7);
      default: return $urandom();
    endcase
  endfunction

  // Mostly pushes and pops with a push share that drifts, so the deque keeps
  // swinging between empty and full; a few status and spare opcodes as noise.
  function automatic in_word_t make_op(int push_pct);
    in_word_t w;
    int unsigned r;
    r = $urandom_range(0, 99);
    w.value = pick_value();
    if (r < 6) begin
      case ($urandom_range(0, 2))
        0: w.opcode = OP_STATUS;
        1: w.opcode = OP_SPARE_6;
        default: w.opcode = OP_SPARE_7;
      endcase
    end else if (r < 20) begin
      w.opcode = OP_SEARCH;
      if (recent_pushes.size() > 0 && $urandom_range(0, 1))
        w.value = recent_pushes[$urandom_range(0, recent_pushes.size() - 1)];
    end else if ($urandom_range(0, 99) < push_pct) begin
      w.opcode = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      recent_pushes.push_back(w.value);
      if (recent_pushes.size() > CELLS) void'(recent_pushes.pop_front());
    end else begin
      w.opcode = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
    end
    return w;
  endfunction

  task automatic queue_op(logic [2:0] op, logic [WORD_W-1:0] v);
    in_word_t w;
    w.opcode = op;
    w.value = v;
    queued_ops.push_back(w);
  endtask

  // The sender pauses here until every queued word went in and every result came out.
  task automatic wait_idle();
    do @(negedge clk); while (queued_ops.size() != 0 || in_valid || predicted_words.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Register write: a setup phase, then an access phase; it lands on the edge where pready is high.
  task automatic set_capacity(logic [CAP_W-1:0] c);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_CAPACITY, 2'b00};
    cfg_pwdata <= 32'(c);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    shadow_cap = c;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, a directed part, then random phases under changing capacity.
  // ---------------------------------------------------------------------------
  initial begin
    int push_pct;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty deque at the reset capacity: both pops underflow, search misses,
    // and the spare opcodes report status.
    queue_op(OP_POP_FRONT, WORD_ONES);
    queue_op(OP_POP_REAR, WORD_MIN);
    queue_op(OP_SEARCH, '0);
    queue_op(OP_STATUS, WORD_MAX);
    queue_op(OP_SPARE_6, 32'h5A5A_A5A5);
    queue_op(OP_SPARE_7, 32'hA5A5_5A5A);
    // Extreme words at both ends, searches that hit and miss, then drain.
    queue_op(OP_PUSH_FRONT, WORD_MAX);
    queue_op(OP_PUSH_REAR, WORD_MIN);
    queue_op(OP_PUSH_FRONT, '0);
    queue_op(OP_PUSH_REAR, WORD_ONES);
    queue_op(OP_SEARCH, WORD_MIN);
    queue_op(OP_SEARCH, 32'h1234_5678);
    queue_op(OP_POP_FRONT, '0);
    queue_op(OP_POP_REAR, '0);
    queue_op(OP_SEARCH, WORD_MAX);
    queue_op(OP_POP_FRONT, '0);
    queue_op(OP_POP_FRONT, '0);
    wait_idle();

    // Capacity of one, then zero which must behave as one.
    set_capacity(5'd1);
    queue_op(OP_PUSH_REAR, 32'd5);
    queue_op(OP_PUSH_FRONT, 32'd6);
    queue_op(OP_POP_FRONT, '0);
    wait_idle();
    set_capacity(5'd0);
    queue_op(OP_PUSH_FRONT, 32'd7);
    queue_op(OP_PUSH_REAR, 32'd8);
    wait_idle();

    // Fill to three, then lower the capacity below the count: pushes overflow
    // and full stays set until pops bring the count down.
    set_capacity(5'd3);
    queue_op(OP_PUSH_REAR, 32'd9);
    queue_op(OP_PUSH_FRONT, 32'd10);
    queue_op(OP_PUSH_REAR, 32'd11);
    wait_idle();
    set_capacity(5'd1);
    queue_op(OP_PUSH_REAR, 32'd12);
    queue_op(OP_STATUS, '0);
    queue_op(OP_POP_REAR, '0);
    queue_op(OP_POP_REAR, '0);
    queue_op(OP_POP_FRONT, '0);
    queue_op(OP_POP_REAR, '0);
    wait_idle();

    // Random phases. The state carries over, so a phase may open with the
    // count already above the new capacity.
    push_pct = 50;
    for (int p = 0; p < N_PHASES; p++) begin
      set_capacity(CAP_PLAN[p]);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (k % 20 == 0) begin
          case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 50;
            default: push_pct = 15;
          endcase
        end
        queued_ops.push_back(make_op(push_pct));
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Word driver. It offers queued words in bursts separated by random gaps.
  // A word that is not taken stays on the bus unchanged, and the choice to
  // offer never looks at in_stall. The prediction is made at the accepting edge.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : word_driver
    logic offer;
    in_word_t next_word;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      next_word = in_data;
      if (in_valid && !in_stall) begin
        predicted_words.push_back(apply_deque_op(in_data));
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_ops.size() > 0) begin
          next_word = queued_ops.pop_front();
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // A third of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= offer;
      in_data <= next_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall. The pattern moves among none, light, heavy and periodic,
  // each mode held for a random span. Once, partway through, the receiver holds off
  // long enough for the block to fill up and stall its input.
  // ---------------------------------------------------------------------------
  stall_mode_e stall_mode = STALL_NONE;
  int mode_left = 0;
  int pattern_ctr = 0;
  int hold_left = 0;
  logic long_hold_done = 1'b0;

  always @(posedge clk) begin : stall_pattern
    logic s;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      pattern_ctr++;
      case (stall_mode)
        STALL_NONE: s = 1'b0;
        STALL_LIGHT: s = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: s = ($urandom_range(0, 3) != 0);
        default: s = ((pattern_ctr % 5) < 2);
      endcase
      if (hold_left > 0) begin
        s = 1'b1;
        hold_left--;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        s = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      out_stall <= s;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result word against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_checker
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (predicted_words.size() == 0) begin
        $error("result word with nothing pending: %h", out_data);
        failures++;
      end else begin
        want = predicted_words.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failures++;
        end
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_data.found);
          failures++;
        end
        if (out_data.item_count !== want.item_count) begin
          $error("item_count: expected %0d, got %0d", want.item_count, out_data.item_count);
          failures++;
        end
        if (out_data.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, out_data.is_empty);
          failures++;
        end
        if (out_data.is_full !== want.is_full) begin
          $error("is_full: expected %0d, got %0d", want.is_full, out_data.is_full);
          failures++;
        end
        if (out_data.front_value !== want.front_value) begin
          $error("front_value: expected %0d, got %0d", want.front_value, out_data.front_value);
          failures++;
        end
        if (out_data.rear_value !== want.rear_value) begin
          $error("rear_value: expected %0d, got %0d", want.rear_value, out_data.rear_value);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without a word moving on either channel ends the run.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire
